@@ rtl/sbcp_pkg.sv @@
// ----------------------------------------------------------------------------
// sbcp_pkg
// Types and constants shared by the seven bit code packer.
// ----------------------------------------------------------------------------
package sbcp_pkg;

   localparam int unsigned CodeWidth = 7;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned TableDepth = 256;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [CodeWidth-1:0] TerminatorCode = 7'h7f;

   typedef enum logic [1:0] {
      OP_DATA = 2'd0,
      OP_END  = 2'd1,
      OP_LOAD = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [ByteWidth-1:0] byte_value;
      logic [CodeWidth-1:0] table_code;
   } req_type;

   typedef struct packed {
      logic [ByteWidth-1:0] packed_byte;
      logic                 last;
   } rsp_type;

endpackage

@@ rtl/seven_bit_code_packer.sv @@
// ----------------------------------------------------------------------------
// seven_bit_code_packer
// An item and its table lookup are registered in stage one; its bytes then
// go to the output queue, which sends one byte per cycle. One item per cycle
// while the queue has room for two bytes, the most that one end item yields.
// Reset clears the packing phase, the pending bits and the output queue; the
// code table is not cleared and holds whatever was loaded.
// ----------------------------------------------------------------------------
module seven_bit_code_packer
   import sbcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic [CodeWidth-1:0] code_mem [TableDepth];

   logic                 s1_valid_ff, s1_valid_in;
   opcode_type           s1_op_ff;
   logic [CodeWidth-1:0] code_ff;

   logic [2:0]           phase_ff, phase_in;
   logic [CodeWidth-1:0] left_ff, left_in;

   rsp_type                queue_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrWidth:0]   count_ff, count_in;

   logic        req_fire;
   logic        rsp_fire;
   logic        s1_fire;
   logic [1:0]  push_num;
   rsp_type     push0;
   rsp_type     push1;
   logic [13:0] data_acc;
   logic [15:0] end_acc;
   logic [13:0] data_shifted;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = queue_ff[rd_ptr_ff];
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign s1_fire   = s1_valid_ff && (count_ff <= (QueuePtrWidth+1)'(QueueDepth - 2));
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // code table
   always_ff @(posedge clock) begin
      if (req_fire && req_item.opcode == OP_LOAD) begin
         code_mem[req_item.byte_value] <= req_item.table_code;
      end
      if (req_fire) begin
         code_ff <= code_mem[req_item.byte_value];
      end
   end

   assign data_acc     = {left_ff, code_ff};
   assign data_shifted = data_acc >> (3'd7 - phase_ff);
   assign end_acc      = 16'({2'b00, left_ff, TerminatorCode}) << (4'(phase_ff) + 4'd1);

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      push_num = 2'd0;
      push0    = '0;
      push1    = '0;
      if (s1_fire) begin
         case (s1_op_ff)
            OP_DATA: begin
               phase_in = phase_ff + 3'd1;
               if (phase_ff == 3'd0) begin
                  left_in = code_ff;
               end else begin
                  push_num          = 2'd1;
                  push0.packed_byte = data_shifted[7:0];
                  push0.last        = 1'b1;
                  left_in           = code_ff & (7'h7f >> phase_ff);
               end
            end
            OP_END: begin
               if (phase_ff != 3'd0) begin
                  phase_in          = 3'd0;
                  left_in           = '0;
                  push0.packed_byte = end_acc[15:8];
                  if (phase_ff == 3'd7) begin
                     push_num   = 2'd1;
                     push0.last = 1'b1;
                  end else begin
                     push_num          = 2'd2;
                     push0.last        = 1'b0;
                     push1.packed_byte = end_acc[7:0];
                     push1.last        = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      wr_ptr_in = wr_ptr_ff + QueuePtrWidth'(push_num);
      rd_ptr_in = rd_ptr_ff + QueuePtrWidth'(rsp_fire);
      count_in  = count_ff + (QueuePtrWidth+1)'(push_num)
                  - (QueuePtrWidth+1)'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         phase_ff    <= '0;
         left_ff     <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         phase_ff    <= phase_in;
         left_ff     <= left_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= req_item.opcode;
      end
      if (push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push0;
      end
      if (push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + QueuePtrWidth'(1)] <= push1;
      end
   end

endmodule

@@ tb/sv/packed_stream_checker.sv @@
// ----------------------------------------------------------------------------
// packed_stream_checker
// Watches both channels of the seven bit code packer, keeps its own copy of
// the code table and packing phase, predicts every packed byte and compares
// each accepted result with the oldest predicted byte.
// ----------------------------------------------------------------------------
module packed_stream_checker
   import sbcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_item,
   output int      error_count,
   output int      outstanding,
   output int      bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CodeWidth-1:0] code_table [TableDepth];
   logic [2:0]           group_phase = '0;
   logic [CodeWidth-1:0] leftover_bits = '0;
   rsp_type              expected_bytes [$];
   int                   mismatch_count = 0;
   int                   byte_count = 0;
   int                   queue_size = 0;

   assign error_count   = mismatch_count;
   assign outstanding   = queue_size;
   assign bytes_checked = byte_count;

   function automatic void predict_packing(input req_type it);
      logic [13:0] merged;
      logic [15:0] aligned;
      int unsigned pend_bits;
      int unsigned total_bits;
      int unsigned rest;
      rsp_type     out_byte;
      pend_bits  = (group_phase == 3'd0) ? 0 : 8 - group_phase;
      total_bits = pend_bits + CodeWidth;
      case (it.opcode)
         OP_LOAD: begin
            code_table[it.byte_value] = it.table_code;
         end
         OP_DATA: begin
            merged = {leftover_bits, code_table[it.byte_value]};
            group_phase = group_phase + 3'd1;
            if (total_bits >= 8) begin
               rest = total_bits - 8;
               out_byte.packed_byte = 8'(merged >> rest);
               out_byte.last = 1'b1;
               expected_bytes.push_back(out_byte);
               leftover_bits = 7'(merged & ((14'd1 << rest) - 14'd1));
            end else begin
               leftover_bits = merged[6:0];
            end
         end
         OP_END: begin
            if (pend_bits != 0) begin
               aligned = {2'b00, leftover_bits, TerminatorCode} << (16 - total_bits);
               out_byte.packed_byte = aligned[15:8];
               out_byte.last = (total_bits <= 8);
               expected_bytes.push_back(out_byte);
               if (total_bits > 8) begin
                  out_byte.packed_byte = aligned[7:0];
                  out_byte.last = 1'b1;
                  expected_bytes.push_back(out_byte);
               end
               group_phase = '0;
               leftover_bits = '0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type exp_byte;
      if (reset) begin
         group_phase = '0;
         leftover_bits = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            byte_count++;
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected packed byte, expected none, got %02h last %0b",
                        $time, rsp_item.packed_byte, rsp_item.last);
            end else begin
               exp_byte = expected_bytes.pop_front();
               if (rsp_item.packed_byte !== exp_byte.packed_byte) begin
                  mismatch_count++;
                  $display("%0t: packed_byte mismatch, expected %02h, got %02h",
                           $time, exp_byte.packed_byte, rsp_item.packed_byte);
               end
               if (rsp_item.last !== exp_byte.last) begin
                  mismatch_count++;
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, exp_byte.last, rsp_item.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_packing(req_item);
         end
      end
      queue_size = expected_bytes.size();
   end

endmodule

@@ tb/sv/tb_seven_bit_code_packer.sv @@
// ----------------------------------------------------------------------------
// tb_seven_bit_code_packer
// Drives table loads, data bytes and end items into the seven bit code
// packer with random gaps and output stalls; the checker beside the block
// predicts and compares the packed byte stream.
// ----------------------------------------------------------------------------
module tb_seven_bit_code_packer;
   import sbcp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemTarget = 1400;
   localparam int CycleLimit = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   logic    steady = 1'b0;
   int      cycle_count = 0;
   int      item_count = 0;
   int      load_count = 0;
   int      data_count = 0;
   int      end_count = 0;
   int      error_count;
   int      outstanding;
   int      bytes_checked;

   logic [TableDepth-1:0] written = '0;
   logic [ByteWidth-1:0]  loaded_addrs [$];

   seven_bit_code_packer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   packed_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] value,
                            input logic [6:0] code);
      req_type it;
      it.opcode = op;
      it.byte_value = value;
      it.table_code = code;
      while (!steady && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (op)
         OP_LOAD: begin
            load_count++;
            if (!written[value]) begin
               written[value] = 1'b1;
               loaded_addrs.push_back(value);
            end
         end
         OP_DATA: data_count++;
         OP_END:  end_count++;
         default: begin
         end
      endcase
      if (op != OP_NONE) item_count++;
   endtask

   task automatic send_random_data();
      logic [7:0] addr;
      addr = 8'($urandom_range(255));
      if (!written[addr]) addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
      send_item(OP_DATA, addr, 7'($urandom_range(127)));
   endtask

   initial begin
      int  run_len;
      int  roll;
      bit  paused;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes of address and code, alternating bit patterns
      send_item(OP_LOAD, 8'h00, 7'h00);
      send_item(OP_LOAD, 8'hff, 7'h7f);
      send_item(OP_LOAD, 8'h55, 7'h2a);
      send_item(OP_LOAD, 8'haa, 7'h55);
      // end with nothing pending, ignored opcode
      send_item(OP_END, 8'h00, 7'h00);
      send_item(OP_NONE, 8'hff, 7'h7f);
      // single code then end gives two bytes
      send_item(OP_DATA, 8'hff, 7'h00);
      send_item(OP_END, 8'hff, 7'h7f);
      // full group of eight codes returns to phase zero
      for (int k = 0; k < 8; k++) begin
         send_item(OP_DATA, (k % 4 == 0) ? 8'hff : (k % 4 == 1) ? 8'h00 :
                   (k % 4 == 2) ? 8'h55 : 8'haa, 7'h00);
      end
      send_item(OP_END, 8'h00, 7'h00);
      // load in the middle of a group
      send_item(OP_DATA, 8'h00, 7'h00);
      send_item(OP_LOAD, 8'h01, 7'h7f);
      send_item(OP_DATA, 8'h01, 7'h00);
      send_item(OP_DATA, 8'haa, 7'h00);
      send_item(OP_END, 8'h00, 7'h00);

      while (item_count < ItemTarget) begin
         steady <= (item_count >= 300 && item_count < 550);
         if (!paused && item_count >= 900) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
         end
         run_len = $urandom_range(1, 17);
         for (int k = 0; k < run_len; k++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
               send_item(OP_LOAD, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else if (roll < 13) begin
               send_item(OP_NONE, 8'($urandom_range(255)), 7'($urandom_range(127)));
            end else begin
               send_random_data();
            end
         end
         if ($urandom_range(9) != 0) send_item(OP_END, 8'($urandom_range(255)),
                                               7'($urandom_range(127)));
         if ($urandom_range(19) == 0) send_item(OP_END, 8'($urandom_range(255)),
                                                7'($urandom_range(127)));
      end
      req_valid <= 1'b0;
      steady <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d table loads, %0d data bytes, %0d end items",
               load_count, data_count, end_count);
      $display("%0d packed bytes compared, %0d table entries loaded",
               bytes_checked, loaded_addrs.size());
      if (error_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/sbcp_pkg.sv
rtl/seven_bit_code_packer.sv
tb/sv/packed_stream_checker.sv
tb/sv/tb_seven_bit_code_packer.sv
